// ===== rtl/psfp_pkg.sv =====
// shared types and constants for the particle sensor frame parser
// no dependencies

package psfp_pkg;

  // frame layout
  localparam logic [7:0] START_BYTE = 8'h42;
  localparam logic [4:0] LAST_POS   = 5'd31;
  localparam logic [4:0] SUM_LEN    = 5'd30;
  localparam int unsigned NUM_WORDS = 12;
  // first measurement word sits at word 2 of the frame (after header and length)
  localparam logic [3:0] FIRST_WORD = 4'd2;
  // measurement words holding the six particle counts
  localparam int unsigned FIRST_COUNT = 6;
  localparam logic [3:0] LAST_INDEX   = 4'(NUM_WORDS - 1);

  typedef logic [7:0]  byte_t;
  typedef logic [15:0] word_t;
  typedef logic [3:0]  word_idx_t;
  typedef word_t [NUM_WORDS-1:0] word_arr_t;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_CSUM = 2'd1,
    STAT_ZERO = 2'd2
  } frame_status_t;

  // frame completion handed from parser to emitter
  typedef struct packed {
    logic          done;
    frame_status_t status;
  } frame_info_t;

endpackage

// ===== rtl/psfp_parser.sv =====
// byte parser: start hunt, running sum, word assembly and measurement store
// depends on psfp_pkg

module psfp_parser (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    accept,
  input  psfp_pkg::byte_t         rx_byte,
  output logic                    at_last_byte,
  output psfp_pkg::frame_info_t   info,
  output psfp_pkg::word_arr_t     words
);

  logic                in_frame_r, in_frame_nxt;
  logic [4:0]          pos_r, pos_nxt;
  psfp_pkg::word_t     sum_r, sum_nxt;
  psfp_pkg::byte_t     hi_r, hi_nxt;
  psfp_pkg::word_arr_t words_r;

  psfp_pkg::word_t     assembled;
  psfp_pkg::word_idx_t widx;
  psfp_pkg::word_idx_t store_idx;
  logic                store_en;
  logic                counts_zero;

  assign assembled    = {hi_r, rx_byte};
  assign widx         = pos_r[4:1];
  assign store_idx    = widx - psfp_pkg::FIRST_WORD;
  assign at_last_byte = in_frame_r && (pos_r == psfp_pkg::LAST_POS);
  assign store_en     = accept && in_frame_r && pos_r[0] &&
                        (widx >= psfp_pkg::FIRST_WORD) &&
                        (store_idx < psfp_pkg::LAST_INDEX + 4'd1);

  // frame state update
  always_comb begin
    in_frame_nxt = in_frame_r;
    pos_nxt      = pos_r;
    sum_nxt      = sum_r;
    hi_nxt       = hi_r;
    if (accept) begin
      if (!in_frame_r) begin
        if (rx_byte == psfp_pkg::START_BYTE) begin
          in_frame_nxt = 1'b1;
          pos_nxt      = 5'd1;
          sum_nxt      = {8'd0, rx_byte};
          hi_nxt       = rx_byte;
        end
      end else begin
        if (pos_r < psfp_pkg::SUM_LEN) begin
          sum_nxt = sum_r + {8'd0, rx_byte};
        end
        if (!pos_r[0]) begin
          hi_nxt = rx_byte;
        end
        if (pos_r == psfp_pkg::LAST_POS) begin
          in_frame_nxt = 1'b0;
          pos_nxt      = 5'd0;
        end else begin
          pos_nxt = pos_r + 5'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r <= 1'b0;
      pos_r      <= 5'd0;
      sum_r      <= '0;
      hi_r       <= '0;
    end else begin
      in_frame_r <= in_frame_nxt;
      pos_r      <= pos_nxt;
      sum_r      <= sum_nxt;
      hi_r       <= hi_nxt;
    end
  end

  // measurement store, one entry per word
  always_ff @(posedge clk) begin
    for (int k = 0; k < psfp_pkg::NUM_WORDS; k++) begin
      if (store_en && (store_idx == 4'(k))) begin
        words_r[k] <= assembled;
      end
    end
  end

  // particle counts all zero
  always_comb begin
    counts_zero = 1'b1;
    for (int k = psfp_pkg::FIRST_COUNT; k < psfp_pkg::NUM_WORDS; k++) begin
      if (words_r[k] != '0) begin
        counts_zero = 1'b0;
      end
    end
  end

  // frame end: the final word is the received checksum
  always_comb begin
    info.done = accept && at_last_byte;
    if (sum_r != assembled) begin
      info.status = psfp_pkg::STAT_CSUM;
    end else if (counts_zero) begin
      info.status = psfp_pkg::STAT_ZERO;
    end else begin
      info.status = psfp_pkg::STAT_OK;
    end
  end

  assign words = words_r;

endmodule

// ===== rtl/psfp_emitter.sv =====
// result emitter: frame holding buffer and output register
// depends on psfp_pkg

module psfp_emitter (
  input  logic                  clk,
  input  logic                  rst_n,
  input  psfp_pkg::frame_info_t info,
  input  psfp_pkg::word_arr_t   words,
  output logic                  busy,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [3:0]            out_word_index,
  output logic [15:0]           out_word_value,
  output logic [1:0]            out_frame_status,
  output logic                  out_last_word
);

  psfp_pkg::word_arr_t     buf_r;
  psfp_pkg::frame_status_t status_r;
  psfp_pkg::word_idx_t     cnt_r, cnt_nxt;
  logic                    busy_r, busy_nxt;
  logic                    valid_r, valid_nxt;
  psfp_pkg::word_idx_t     idx_r;
  psfp_pkg::word_t         value_r;
  psfp_pkg::frame_status_t ostat_r;
  logic                    last_r;
  logic                    move;
  logic                    load;

  assign load = info.done && !busy_r;
  assign move = busy_r && (!valid_r || out_ready);

  // buffer control
  always_comb begin
    cnt_nxt   = cnt_r;
    busy_nxt  = busy_r;
    valid_nxt = valid_r;
    if (out_ready) begin
      valid_nxt = 1'b0;
    end
    if (load) begin
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (move) begin
      valid_nxt = 1'b1;
      cnt_nxt   = cnt_r + 4'd1;
      if (cnt_r == psfp_pkg::LAST_INDEX) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      busy_r  <= 1'b0;
      valid_r <= 1'b0;
    end else begin
      cnt_r   <= cnt_nxt;
      busy_r  <= busy_nxt;
      valid_r <= valid_nxt;
    end
  end

  // payload capture
  always_ff @(posedge clk) begin
    if (load) begin
      buf_r    <= words;
      status_r <= info.status;
    end
    if (move) begin
      idx_r   <= cnt_r;
      value_r <= buf_r[cnt_r];
      ostat_r <= status_r;
      last_r  <= (cnt_r == psfp_pkg::LAST_INDEX);
    end
  end

  assign busy             = busy_r;
  assign out_valid        = valid_r;
  assign out_word_index   = idx_r;
  assign out_word_value   = value_r;
  assign out_frame_status = ostat_r;
  assign out_last_word    = last_r;

endmodule

// ===== rtl/particle_sensor_frame_parser_top.sv =====
// Particle sensor frame parser: takes one serial byte per item, hunts for the
// start byte 0x42, collects a 32-byte frame with a 16-bit additive checksum
// over bytes 0..29, and after byte 31 emits twelve measurement-word items,
// each carrying the frame status (ok, checksum mismatch, or all particle
// counts zero). Input bytes are taken one per cycle. The twelve results
// of a frame leave from a holding buffer one per cycle, while out_ready
// is high, through the output register as the next frame's bytes keep
// arriving; only the final byte of a following frame waits if the
// previous frame's results are not yet all moved into the output register.
// depends on psfp_pkg, psfp_parser, psfp_emitter

module particle_sensor_frame_parser_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  out_word_index,
  output logic [15:0] out_word_value,
  output logic [1:0]  out_frame_status,
  output logic        out_last_word
);

  logic                  accept;
  logic                  at_last_byte;
  logic                  busy;
  psfp_pkg::frame_info_t info;
  psfp_pkg::word_arr_t   words;

  // hold the frame-ending byte while the buffer is still draining
  assign in_ready = !(at_last_byte && busy);
  assign accept   = in_valid && in_ready;

  psfp_parser u_parser (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .rx_byte      (in_rx_byte),
    .at_last_byte (at_last_byte),
    .info         (info),
    .words        (words)
  );

  psfp_emitter u_emitter (
    .clk              (clk),
    .rst_n            (rst_n),
    .info             (info),
    .words            (words),
    .busy             (busy),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_word_index   (out_word_index),
    .out_word_value   (out_word_value),
    .out_frame_status (out_frame_status),
    .out_last_word    (out_last_word)
  );

endmodule
